// ===== rtl/nncg_pkg.sv =====
// ----------------------------------------------------------------------------
// nncg_pkg
// Shared constants for the nearest-neighbor complex gridder: action codes,
// configuration register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package nncg_pkg;

    // Action codes carried in the input word
    localparam logic [1:0] ACT_ACCUM      = 2'd0;
    localparam logic [1:0] ACT_READ       = 2'd1;
    localparam logic [1:0] ACT_READ_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    // Field widths
    localparam int ACTION_BITS = 2;
    localparam int INDEX_BITS  = 16;
    localparam int REG_BITS    = 7;
    localparam int CFG_IDX_BITS = 1;

    // Register reset values
    localparam logic [REG_BITS-1:0] GRID_WIDTH_RESET  = 7'd64;
    localparam logic [REG_BITS-1:0] GRID_HEIGHT_RESET = 7'd64;

endpackage

// ===== rtl/nncg_ram.sv =====
// ----------------------------------------------------------------------------
// nncg_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module nncg_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/nearest_neighbor_complex_gridder.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_complex_gridder
// Accumulates complex samples into a 2D grid of saturating fixed-point cells
// held in two on-chip RAMs (real and imaginary sums); also reads and
// read-and-clears cells.
//
//  Channel  | Dir | Contents
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | action, x_index, y_index, sample_real, sample_imag; tlast
//  m_axis   | out | in_range, cell_real, cell_imag, saturated; tlast=batch_end
//  cfg      | in  | write-only: 0 grid_width, 1 grid_height
//
// Each word goes through accept, RAM read, then update and write-back; the
// read-modify-write over the RAM's registered read port sets these steps.
// After reset a clearing pass zeroes all GRID_MAX_X*GRID_MAX_Y cells, one
// cell per cycle; s_tready stays low during it.
// A finished result waits in the output register while the next word is
// accepted; the update step waits only if that register is still full.
// ----------------------------------------------------------------------------
module nearest_neighbor_complex_gridder #(
    parameter int GRID_MAX_X  = 64,
    parameter int GRID_MAX_Y  = 64,
    parameter int SAMPLE_BITS = 24,
    parameter int ACC_BITS    = 40
) (
    input  logic aclk,
    input  logic aresetn,

    // tdata: action, x_index, y_index, sample_real, sample_imag (low bit up)
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    input  logic [((34 + 2*SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                                            s_tlast,

    // tdata: in_range, cell_real, cell_imag, saturated (low bit up)
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    output logic [((2*ACC_BITS + 2 + 7) / 8) * 8 - 1:0]     m_tdata,
    output logic                                            m_tlast,

    input  logic                                            cfg_we,
    input  logic [nncg_pkg::CFG_IDX_BITS-1:0]               cfg_index,
    input  logic [nncg_pkg::REG_BITS-1:0]                   cfg_wdata
);

    import nncg_pkg::*;

    // Geometry
    localparam int CELL_COUNT = GRID_MAX_X * GRID_MAX_Y;
    localparam int CELL_BITS  = CELL_COUNT > 1 ? $clog2(CELL_COUNT) : 1;
    localparam int X_BITS     = GRID_MAX_X > 1 ? $clog2(GRID_MAX_X) : 1;
    localparam int Y_BITS     = GRID_MAX_Y > 1 ? $clog2(GRID_MAX_Y) : 1;

    // Word layout
    localparam int OUT_W    = ((2*ACC_BITS + 2 + 7) / 8) * 8;
    localparam int X_LSB    = ACTION_BITS;
    localparam int Y_LSB    = X_LSB + INDEX_BITS;
    localparam int SR_LSB   = Y_LSB + INDEX_BITS;
    localparam int SI_LSB   = SR_LSB + SAMPLE_BITS;
    localparam int OUT_USED = 2*ACC_BITS + 2;

    // Saturating adder width and limits
    localparam int SUM_BITS = (ACC_BITS > SAMPLE_BITS ? ACC_BITS : SAMPLE_BITS) + 1;
    localparam logic signed [SUM_BITS-1:0] SUM_HI =
        {{(SUM_BITS-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_LO =
        {{(SUM_BITS-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CALC
    } state_t;

    // Registers
    state_t                        state_reg,       state_next;
    logic [CELL_BITS-1:0]          clr_addr_reg,    clr_addr_next;
    logic [REG_BITS-1:0]           grid_width_reg,  grid_width_next;
    logic [REG_BITS-1:0]           grid_height_reg, grid_height_next;
    logic [ACTION_BITS-1:0]        action_reg,      action_next;
    logic                          ok_reg,          ok_next;
    logic [CELL_BITS-1:0]          addr_reg,        addr_next;
    logic signed [SAMPLE_BITS-1:0] sr_reg,          sr_next;
    logic signed [SAMPLE_BITS-1:0] si_reg,          si_next;
    logic                          last_reg,        last_next;
    logic                          m_valid_reg,     m_valid_next;
    logic [OUT_W-1:0]              m_data_reg,      m_data_next;
    logic                          m_last_reg,      m_last_next;

    // RAM ports
    logic                ram_we;
    logic [CELL_BITS-1:0] ram_waddr;
    logic [ACC_BITS-1:0] ram_wdata_re, ram_wdata_im;
    logic                ram_re;
    logic [ACC_BITS-1:0] ram_rdata_re, ram_rdata_im;

    // Input unpack and range check
    logic signed [INDEX_BITS-1:0] in_x, in_y;
    logic [INDEX_BITS-1:0]        w_lim, h_lim;
    logic                         in_ok;
    logic [CELL_BITS-1:0]         in_addr;

    // Update datapath
    logic signed [SUM_BITS-1:0] sum_re, sum_im;
    logic signed [ACC_BITS-1:0] new_re, new_im;
    logic                       clip_re, clip_im;
    logic                       can_load;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign can_load = !m_valid_reg || m_tready;

    // Active limits clamp at the built grid size
    always_comb begin
        in_x  = s_tdata[X_LSB +: INDEX_BITS];
        in_y  = s_tdata[Y_LSB +: INDEX_BITS];
        w_lim = (INDEX_BITS'(grid_width_reg) > INDEX_BITS'(GRID_MAX_X)) ?
                INDEX_BITS'(GRID_MAX_X) : INDEX_BITS'(grid_width_reg);
        h_lim = (INDEX_BITS'(grid_height_reg) > INDEX_BITS'(GRID_MAX_Y)) ?
                INDEX_BITS'(GRID_MAX_Y) : INDEX_BITS'(grid_height_reg);
        in_ok = !in_x[INDEX_BITS-1] && !in_y[INDEX_BITS-1] &&
                (INDEX_BITS'(in_x) < w_lim) && (INDEX_BITS'(in_y) < h_lim);
        in_addr = CELL_BITS'(in_y[Y_BITS-1:0]) * CELL_BITS'(GRID_MAX_X)
                + CELL_BITS'(in_x[X_BITS-1:0]);
    end

    // Saturating accumulate
    always_comb begin
        sum_re = {{(SUM_BITS-ACC_BITS){ram_rdata_re[ACC_BITS-1]}}, ram_rdata_re}
               + {{(SUM_BITS-SAMPLE_BITS){sr_reg[SAMPLE_BITS-1]}}, sr_reg};
        sum_im = {{(SUM_BITS-ACC_BITS){ram_rdata_im[ACC_BITS-1]}}, ram_rdata_im}
               + {{(SUM_BITS-SAMPLE_BITS){si_reg[SAMPLE_BITS-1]}}, si_reg};
        clip_re = (sum_re > SUM_HI) || (sum_re < SUM_LO);
        clip_im = (sum_im > SUM_HI) || (sum_im < SUM_LO);
        if (sum_re > SUM_HI) begin
            new_re = ACC_BITS'(SUM_HI);
        end else if (sum_re < SUM_LO) begin
            new_re = ACC_BITS'(SUM_LO);
        end else begin
            new_re = ACC_BITS'(sum_re);
        end
        if (sum_im > SUM_HI) begin
            new_im = ACC_BITS'(SUM_HI);
        end else if (sum_im < SUM_LO) begin
            new_im = ACC_BITS'(SUM_LO);
        end else begin
            new_im = ACC_BITS'(sum_im);
        end
    end

    // Next-state and RAM control
    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        action_next      = action_reg;
        ok_next          = ok_reg;
        addr_next        = addr_reg;
        sr_next          = sr_reg;
        si_next          = si_reg;
        last_next        = last_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg;
        ram_wdata_re     = '0;
        ram_wdata_im     = '0;
        ram_re           = 1'b0;

        // Config writes are taken in any state
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_next  = cfg_wdata;
                CFG_GRID_HEIGHT: grid_height_next = cfg_wdata;
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CELL_BITS'(CELL_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    action_next = s_tdata[ACTION_BITS-1:0];
                    ok_next     = in_ok;
                    addr_next   = in_addr;
                    sr_next     = s_tdata[SR_LSB +: SAMPLE_BITS];
                    si_next     = s_tdata[SI_LSB +: SAMPLE_BITS];
                    last_next   = s_tlast;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                ram_re     = 1'b1;
                state_next = S_CALC;
            end
            S_CALC: begin
                if (can_load) begin
                    m_valid_next = 1'b1;
                    m_last_next  = last_reg;
                    m_data_next  = '0;
                    m_data_next[0] = ok_reg;
                    if (ok_reg) begin
                        case (action_reg)
                            ACT_ACCUM: begin
                                ram_we       = 1'b1;
                                ram_wdata_re = new_re;
                                ram_wdata_im = new_im;
                                m_data_next[1 +: ACC_BITS]          = new_re;
                                m_data_next[1+ACC_BITS +: ACC_BITS] = new_im;
                                m_data_next[OUT_USED-1]             = clip_re || clip_im;
                            end
                            ACT_READ_CLEAR: begin
                                ram_we = 1'b1;
                                m_data_next[1 +: ACC_BITS]          = ram_rdata_re;
                                m_data_next[1+ACC_BITS +: ACC_BITS] = ram_rdata_im;
                            end
                            default: begin
                                m_data_next[1 +: ACC_BITS]          = ram_rdata_re;
                                m_data_next[1+ACC_BITS +: ACC_BITS] = ram_rdata_im;
                            end
                        endcase
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            m_valid_reg     <= m_valid_next;
            action_reg      <= action_next;
            ok_reg          <= ok_next;
            addr_reg        <= addr_next;
            sr_reg          <= sr_next;
            si_reg          <= si_next;
            last_reg        <= last_next;
            m_data_reg      <= m_data_next;
            m_last_reg      <= m_last_next;
        end
    end

    // Cell sum memories
    nncg_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (CELL_COUNT)
    ) u_ram_re (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata_re),
        .rd_en   (ram_re),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata_re)
    );

    nncg_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (CELL_COUNT)
    ) u_ram_im (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata_im),
        .rd_en   (ram_re),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata_im)
    );

    // Checks
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("word accepted during clearing pass");

    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> !ram_we)
        else $error("RAM write collides with read of the cell in flight");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[0]) |->
            (m_data_reg[OUT_USED-1:1] == '0))
        else $error("out-of-range result carries nonzero sums");

    a_result_after_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC && can_load) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("update step did not load the result register");

endmodule
